// ===== design/scancode_ring_buffer_with_backspace_defines.svh =====
// assertion macros for the scan code key buffer
// no dependencies; included by the top level
`ifndef SCANCODE_RING_BUFFER_WITH_BACKSPACE_DEFINES_SVH
`define SCANCODE_RING_BUFFER_WITH_BACKSPACE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/scrb_pkg.sv =====
// shared types, codes and the set-1 scan code table for the key buffer
// no dependencies
package scrb_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  localparam logic [1:0] MODE_SCAN  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  localparam logic [7:0] SC_F5  = 8'h3F;
  localparam logic [7:0] SC_ESC = 8'h01;
  localparam logic [7:0] SC_F1  = 8'h3B;
  localparam logic [7:0] SC_F2  = 8'h3C;
  localparam logic [7:0] SC_F3  = 8'h3D;

  localparam logic [6:0] ASCII_BS = 7'd8;

  typedef enum logic [3:0] {
    STAT_NO_KEY   = 4'd0,
    STAT_FULL     = 4'd1,
    STAT_DELETED  = 4'd2,
    STAT_VALID    = 4'd3,
    STAT_UNMAPPED = 4'd4,
    STAT_CAPTURE  = 4'd5,
    STAT_KILL     = 4'd6,
    STAT_PAUSE_C  = 4'd7,
    STAT_PAUSE_L  = 4'd8,
    STAT_PAUSE_R  = 4'd9
  } status_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

  function automatic logic [6:0] key_ascii(input logic [6:0] idx);
    logic [6:0] ch;
    unique case (idx)
      7'd2:  ch = 7'h31;
      7'd3:  ch = 7'h32;
      7'd4:  ch = 7'h33;
      7'd5:  ch = 7'h34;
      7'd6:  ch = 7'h35;
      7'd7:  ch = 7'h36;
      7'd8:  ch = 7'h37;
      7'd9:  ch = 7'h38;
      7'd10: ch = 7'h39;
      7'd11: ch = 7'h30;
      7'd12: ch = 7'h2D;
      7'd13: ch = 7'h3D;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = 7'h71;
      7'd17: ch = 7'h77;
      7'd18: ch = 7'h65;
      7'd19: ch = 7'h72;
      7'd20: ch = 7'h74;
      7'd21: ch = 7'h79;
      7'd22: ch = 7'h75;
      7'd23: ch = 7'h69;
      7'd24: ch = 7'h6F;
      7'd25: ch = 7'h70;
      7'd26: ch = 7'h5B;
      7'd27: ch = 7'h5D;
      7'd28: ch = 7'h0A;
      7'd30: ch = 7'h61;
      7'd31: ch = 7'h73;
      7'd32: ch = 7'h64;
      7'd33: ch = 7'h66;
      7'd34: ch = 7'h67;
      7'd35: ch = 7'h68;
      7'd36: ch = 7'h6A;
      7'd37: ch = 7'h6B;
      7'd38: ch = 7'h6C;
      7'd39: ch = 7'h3B;
      7'd40: ch = 7'h27;
      7'd41: ch = 7'h7C;
      7'd43: ch = 7'h7C;
      7'd44: ch = 7'h7A;
      7'd45: ch = 7'h78;
      7'd46: ch = 7'h63;
      7'd47: ch = 7'h76;
      7'd48: ch = 7'h62;
      7'd49: ch = 7'h6E;
      7'd50: ch = 7'h6D;
      7'd51: ch = 7'h2C;
      7'd52: ch = 7'h2E;
      7'd53: ch = 7'h2F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      7'd74: ch = 7'h2D;
      7'd78: ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_up(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_down(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(BUFFER_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ===== design/scrb_ctrl.sv =====
// controller: capture/execute sequencer and result strobe
// depends on scrb_pkg
module scrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output scrb_pkg::ctl_cmd_t  cmd
);
  import scrb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  assign busy        = (state_r == S_EXEC);
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.exec    = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;

endmodule

// ===== design/scrb_dp.sv =====
// datapath: key store, occupancy bits, pointers, translation and result registers
// depends on scrb_pkg
module scrb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  scrb_pkg::ctl_cmd_t  cmd,
  input  logic [1:0]          in_mode,
  input  logic [7:0]          in_scan_code,
  output logic [3:0]          out_status,
  output logic [6:0]          out_character,
  output logic                out_key_available
);
  import scrb_pkg::*;

  logic [6:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] occ_r, occ_nxt;
  logic [ADDR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]       pk_ptr_r, pk_ptr_nxt;
  logic [1:0]              mode_r;
  logic [7:0]              code_r;
  logic [6:0]              rd_data_r;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [6:0]              wr_data;
  status_t                 status_nxt, status_r;
  logic [6:0]              char_nxt, char_r;
  logic                    avail_r;

  assign rd_addr = (in_mode == MODE_READ) ? rd_ptr_r : pk_ptr_r;

  always_comb begin
    logic [6:0]        ch;
    logic [ADDR_W-1:0] prev;
    ch         = key_ascii(code_r[6:0]);
    prev       = ptr_down(wr_ptr_r);
    occ_nxt    = occ_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    pk_ptr_nxt = pk_ptr_r;
    wr_en      = 1'b0;
    wr_data    = ch;
    status_nxt = STAT_NO_KEY;
    char_nxt   = 7'h00;
    unique case (mode_r)
      MODE_SCAN: begin
        priority if (code_r == SC_F5) begin
          status_nxt = STAT_CAPTURE;
        end else if (code_r == SC_ESC) begin
          status_nxt = STAT_KILL;
        end else if (code_r == SC_F1) begin
          status_nxt = STAT_PAUSE_C;
        end else if (code_r == SC_F2) begin
          status_nxt = STAT_PAUSE_L;
        end else if (code_r == SC_F3) begin
          status_nxt = STAT_PAUSE_R;
        end else if (code_r[7]) begin
          status_nxt = STAT_NO_KEY;
        end else if (occ_r[wr_ptr_r]) begin
          status_nxt = STAT_FULL;
        end else if (ch == ASCII_BS) begin
          status_nxt = STAT_DELETED;
          if (occ_r[prev]) begin
            occ_nxt[prev] = 1'b0;
            wr_ptr_nxt    = prev;
            if (pk_ptr_r == wr_ptr_r) pk_ptr_nxt = ptr_down(pk_ptr_r);
          end
        end else if (ch == 7'h00) begin
          status_nxt = STAT_UNMAPPED;
        end else begin
          status_nxt        = STAT_VALID;
          wr_en             = 1'b1;
          occ_nxt[wr_ptr_r] = 1'b1;
          wr_ptr_nxt        = ptr_up(wr_ptr_r);
        end
      end
      MODE_READ: begin
        if (occ_r[rd_ptr_r]) begin
          if (pk_ptr_r == rd_ptr_r) pk_ptr_nxt = ptr_up(pk_ptr_r);
          char_nxt          = rd_data_r;
          occ_nxt[rd_ptr_r] = 1'b0;
          rd_ptr_nxt        = ptr_up(rd_ptr_r);
          status_nxt        = STAT_VALID;
        end
      end
      MODE_PEEK: begin
        if (occ_r[pk_ptr_r]) begin
          char_nxt   = rd_data_r;
          pk_ptr_nxt = ptr_up(pk_ptr_r);
          status_nxt = STAT_VALID;
        end
      end
      MODE_QUERY: begin
        if (occ_r[rd_ptr_r]) status_nxt = STAT_VALID;
      end
      default: status_nxt = STAT_NO_KEY;
    endcase
  end

  // key store
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_data_r <= mem[rd_addr];
    if (cmd.exec && wr_en) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      pk_ptr_r <= '0;
    end else if (cmd.exec) begin
      occ_r    <= occ_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pk_ptr_r <= pk_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      code_r <= in_scan_code;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      char_r   <= char_nxt;
      avail_r  <= occ_nxt[rd_ptr_nxt];
    end
  end

  assign out_status        = status_r;
  assign out_character     = char_r;
  assign out_key_available = avail_r;

endmodule

// ===== design/scancode_ring_buffer_with_backspace.sv =====
// top level: set-1 scan code translator feeding a 256-entry key store
// one beat is a capture step with store read, then an execute step with store write
// result strobe out_valid rises in the cycle after busy
// start is ignored while busy, so a new beat waits until execute ends; single store read and write port
// synchronous active-low reset empties the store (occupancy bits) and zeroes pointers
// depends on scrb_pkg, scrb_ctrl, scrb_dp and the assertion macro header
`include "scancode_ring_buffer_with_backspace_defines.svh"

module scancode_ring_buffer_with_backspace (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  output logic [3:0] out_status,
  output logic [6:0] out_character,
  output logic       out_key_available
);
  import scrb_pkg::*;

  ctl_cmd_t cmd;

  scrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  scrb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_mode),
    .in_scan_code      (in_scan_code),
    .out_status        (out_status),
    .out_character     (out_character),
    .out_key_available (out_key_available)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_exec_single, clk, rst_n, busy, !busy && out_valid)
  `ASSERT_SAME(a_strobe_after_exec, clk, rst_n, out_valid, !busy)
  `ASSERT_SAME(a_char_only_valid, clk, rst_n, out_valid && (out_status != STAT_VALID),
               out_character == 7'h00)

endmodule
